// ===== src/sot_pkg.sv =====
package sot_pkg;

	localparam int SLOTS_DEFAULT = 256;

	typedef enum logic [3:0] {
		CMD_CREATE  = 4'd0,
		CMD_DESTROY = 4'd1,
		CMD_GRAB    = 4'd2,
		CMD_QUERY   = 4'd3,
		CMD_SET     = 4'd4,
		CMD_RESET   = 4'd5,
		CMD_SATISFY = 4'd6,
		CMD_RELEASE = 4'd7,
		CMD_ABANDON = 4'd8
	} cmd_t;

	localparam logic [2:0] KIND_EVENT    = 3'd0;
	localparam logic [2:0] KIND_SEMA     = 3'd1;
	localparam logic [2:0] KIND_MUTEX    = 3'd2;
	localparam logic [2:0] KIND_INTERNAL = 3'd3;
	localparam logic [2:0] KIND_UNKNOWN  = 3'd4;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_BAD       = 3'd1;
	localparam logic [2:0] ERR_SEM_LIMIT = 3'd2;
	localparam logic [2:0] ERR_NOT_OWNED = 3'd3;
	localparam logic [2:0] ERR_FULL      = 3'd4;

	typedef struct packed {
		logic [3:0]  command;
		logic [7:0]  slot;
		logic [1:0]  object_kind;
		logic [31:0] value_a;
		logic [31:0] value_b;
		logic [30:0] thread_id;
	} item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] low;
		logic [31:0] high;
		logic [31:0] gen;
		logic [15:0] refc;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic        ok;
		logic [2:0]  error_code;
		logic        signaled;
		logic [30:0] previous_value;
		logic [31:0] value_low;
		logic [31:0] value_high;
		logic        owned;
		logic        abandoned;
		logic [7:0]  new_slot;
	} result_t;

	function automatic logic is_signaled(logic [2:0] kind, logic [31:0] low,
		logic [30:0] tid);
		logic s;
		s = 1'b0;
		if (kind == KIND_EVENT || kind == KIND_INTERNAL) s = (low != 32'd0);
		else if (kind == KIND_SEMA) s = !low[31] && (low != 32'd0);
		else if (kind == KIND_MUTEX) s = (low == 32'd0) || low[31] || (low == {1'b0, tid});
		return s;
	endfunction

endpackage

// ===== src/sot_ram.sv =====
module sot_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== src/sot_exec.sv =====
module sot_exec import sot_pkg::*; #(
	parameter int SLOTS = SLOTS_DEFAULT
) (
	input  item_t                      item,
	input  entry_t                     ent,
	input  logic [$clog2(SLOTS+1)-1:0] nf,
	input  logic [31:0]                gc,
	output result_t                    res,
	output logic                       wr_en,
	output logic [$clog2(SLOTS)-1:0]   wr_addr,
	output entry_t                     wr_data,
	output logic [$clog2(SLOTS+1)-1:0] nf_d,
	output logic [31:0]                gc_d
);
	localparam int NFW = $clog2(SLOTS+1);
	localparam int AW  = $clog2(SLOTS);

	logic        valid;
	logic [31:0] tid32;
	logic [32:0] sum;
	entry_t      n;

	assign tid32 = {1'b0, item.thread_id};
	assign valid = (item.slot != 8'd0) && (32'(item.slot) < 32'(nf))
		&& (32'(item.slot) < 32'(SLOTS));
	assign sum = {1'b0, ent.low} + {1'b0, item.value_a};

	always_comb begin
		res     = '0;
		n       = ent;
		wr_en   = 1'b0;
		wr_addr = AW'(item.slot);
		nf_d    = nf;
		gc_d    = gc;
		if (item.command == CMD_CREATE) begin
			if (32'(nf) >= 32'(SLOTS)) begin
				res.error_code = ERR_FULL;
			end else begin
				wr_en        = 1'b1;
				wr_addr      = AW'(nf);
				n.kind       = {1'b0, item.object_kind};
				n.low        = item.value_a;
				n.high       = item.value_b;
				n.gen        = gc;
				n.refc       = 16'd1;
				gc_d         = gc + 32'd1;
				nf_d         = nf + NFW'(1);
				res.ok       = 1'b1;
				res.new_slot = 8'(nf);
			end
		end else if (item.command > CMD_ABANDON || !valid) begin
			res.error_code = ERR_BAD;
		end else begin
			wr_en = 1'b1;
			unique case (item.command)
				CMD_DESTROY: begin
					if (ent.refc == 16'd0) res.error_code = ERR_BAD;
					else begin
						n.kind = KIND_UNKNOWN;
						n.gen  = gc;
						gc_d   = gc + 32'd1;
						n.refc = ent.refc - 16'd1;
						res.ok = 1'b1;
					end
				end
				CMD_GRAB: begin
					if (ent.refc == 16'd0 || ent.refc == 16'hFFFF) res.error_code = ERR_BAD;
					else begin
						n.refc = ent.refc + 16'd1;
						res.ok = 1'b1;
					end
				end
				CMD_QUERY: begin
					if (ent.kind == KIND_EVENT || ent.kind == KIND_INTERNAL
						|| ent.kind == KIND_SEMA) begin
						res.value_low  = ent.low;
						res.value_high = ent.high;
						res.ok         = 1'b1;
						res.signaled   = is_signaled(ent.kind, ent.low, item.thread_id);
					end else if (ent.kind == KIND_MUTEX) begin
						res.value_low  = ent.low;
						res.value_high = ent.low[31] ? 32'd0 : ent.high;
						res.owned      = (ent.low == tid32);
						res.abandoned  = ent.low[31];
						res.ok         = 1'b1;
						res.signaled   = is_signaled(ent.kind, ent.low, item.thread_id);
					end else res.error_code = ERR_BAD;
				end
				CMD_SET, CMD_RESET: begin
					if (ent.kind != KIND_EVENT && ent.kind != KIND_INTERNAL)
						res.error_code = ERR_BAD;
					else begin
						n.low        = (item.command == CMD_SET) ? 32'd1 : 32'd0;
						res.ok       = 1'b1;
						res.signaled = is_signaled(n.kind, n.low, item.thread_id);
					end
				end
				CMD_SATISFY: begin
					if (ent.kind == KIND_EVENT || ent.kind == KIND_INTERNAL) begin
						if (ent.high == 32'd0) n.low = 32'd0;
						res.ok       = 1'b1;
						res.signaled = is_signaled(n.kind, n.low, item.thread_id);
					end else if (ent.kind == KIND_SEMA) begin
						if (!ent.low[31] && ent.low != 32'd0) begin
							n.low  = ent.low - 32'd1;
							res.ok = 1'b1;
						end
						res.signaled = is_signaled(n.kind, n.low, item.thread_id);
					end else if (ent.kind == KIND_MUTEX) begin
						if (ent.low == tid32) begin
							if (ent.high != 32'h7FFF_FFFF) begin
								n.high = ent.high + 32'd1;
								res.ok = 1'b1;
							end
						end else if (ent.low == 32'd0 || ent.low[31]) begin
							n.low  = tid32;
							n.high = 32'd1;
							if (ent.low[31]) begin
								n.gen         = ent.gen + 32'd1;
								res.abandoned = 1'b1;
							end
							res.ok = 1'b1;
						end
						res.owned    = (n.low == tid32);
						res.signaled = is_signaled(n.kind, n.low, item.thread_id);
					end else res.error_code = ERR_BAD;
				end
				CMD_RELEASE: begin
					if (ent.kind == KIND_SEMA) begin
						if (sum[32] || sum[31:0] > ent.high) res.error_code = ERR_SEM_LIMIT;
						else begin
							n.low              = sum[31:0];
							res.previous_value = ent.low[30:0];
							res.ok             = 1'b1;
						end
						res.signaled = is_signaled(n.kind, n.low, item.thread_id);
					end else if (ent.kind == KIND_MUTEX) begin
						if (ent.low != tid32 || ent.high == 32'd0) res.error_code = ERR_NOT_OWNED;
						else begin
							res.previous_value = ent.high[30:0];
							if (!ent.high[31] && ent.high > 32'd1) n.high = ent.high - 32'd1;
							else begin
								n.high = 32'd0;
								n.low  = 32'd0;
							end
							res.ok = 1'b1;
						end
						res.owned    = (n.low == tid32);
						res.signaled = is_signaled(n.kind, n.low, item.thread_id);
					end else res.error_code = ERR_BAD;
				end
				default: begin
					if (ent.kind != KIND_MUTEX) res.error_code = ERR_BAD;
					else begin
						if (ent.low != tid32 || ent.high == 32'd0) res.error_code = ERR_NOT_OWNED;
						else begin
							n.low  = ~tid32 + 32'd1;
							n.high = 32'd0;
							n.gen  = ent.gen + 32'd1;
							res.ok = 1'b1;
						end
						res.owned    = (n.low == tid32);
						res.signaled = is_signaled(n.kind, n.low, item.thread_id);
					end
				end
			endcase
		end
		wr_data = n;
	end
endmodule

// ===== src/sync_object_table_core.sv =====
// Synchronization object table: events, semaphores, recursive mutexes and
// internal wait slots, addressed by slot number.
// Slave channel s_*: one command per transfer. tuser carries the command
// code, tdata the operands. Master channel m_*: exactly one result per
// command, in command order.
// Pipeline: an accepted command sits in stage 1 while its table entry is
// read from the single-port-read entry RAM (registered read). In the next
// cycle stage 1 computes the result; when it advances, it writes the entry
// back and loads the result register. Throughput is one command per cycle
// while the receiver takes results; the last write is forwarded, so
// commands on the same slot may follow back to back.
// When the receiver stalls, the result register holds, stage 1 holds one
// more command, and s_tready drops once both are full.
// Reset clears the pipeline valids, the slot allocator (next slot 1) and the
// generation counter (1). The RAM is not cleared: only entries of slots below
// the allocator are used, and each of them was written by its create.
module sync_object_table_core import sot_pkg::*; #(
	parameter int SLOTS = SLOTS_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [7:0] slot, [9:8] object_kind, [41:10] value_a, [73:42] value_b,
	// [104:74] thread_id, [111:105] zero
	input  logic [111:0] s_tdata,
	// [3:0] command
	input  logic [3:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [0] ok, [3:1] error_code, [4] signaled, [35:5] previous_value,
	// [67:36] value_low, [99:68] value_high, [100] owned, [101] abandoned,
	// [109:102] new_slot, [111:110] zero
	output logic [111:0] m_tdata
);
	localparam int NFW = $clog2(SLOTS+1);
	localparam int AW  = $clog2(SLOTS);

	logic                s1_valid_q;
	item_t               item_s1;
	item_t               in_item;
	logic                accept, advance;
	logic [NFW-1:0]      nf_q, nf_d;
	logic [31:0]         gc_q, gc_d;
	entry_t              ram_rdata, ent;
	logic [ENTRY_W-1:0]  ram_rd_bits;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	entry_t              wr_data;
	logic                fwd_valid_q;
	logic [AW-1:0]       fwd_addr_q;
	entry_t              fwd_data_q;
	result_t             res, out_q;
	logic                out_valid_q;

	assign in_item.command     = s_tuser;
	assign in_item.slot        = s_tdata[7:0];
	assign in_item.object_kind = s_tdata[9:8];
	assign in_item.value_a     = s_tdata[41:10];
	assign in_item.value_b     = s_tdata[73:42];
	assign in_item.thread_id   = s_tdata[104:74];

	assign advance  = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || advance;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) item_s1 <= in_item;
	end

	sot_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
		.clk   (clk),
		.we    (advance && wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (accept),
		.raddr (AW'(in_item.slot)),
		.rdata (ram_rd_bits)
	);
	assign ram_rdata = entry_t'(ram_rd_bits);

	// the read issued alongside the last write returned old data
	assign ent = (fwd_valid_q && fwd_addr_q == AW'(item_s1.slot)) ? fwd_data_q : ram_rdata;

	sot_exec #(.SLOTS(SLOTS)) u_exec (
		.item    (item_s1),
		.ent     (ent),
		.nf      (nf_q),
		.gc      (gc_q),
		.res     (res),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.nf_d    (nf_d),
		.gc_d    (gc_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nf_q        <= NFW'(1);
			gc_q        <= 32'd1;
			fwd_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				nf_q <= nf_d;
				gc_q <= gc_d;
			end
			if (advance && wr_en) fwd_valid_q <= 1'b1;
			if (advance) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && wr_en) begin
			fwd_addr_q <= wr_addr;
			fwd_data_q <= wr_data;
		end
		if (advance) out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q.new_slot, out_q.abandoned, out_q.owned, out_q.value_high,
		out_q.value_low, out_q.previous_value, out_q.signaled, out_q.error_code, out_q.ok};

`ifndef ASSERT_OFF
	a_nf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(nf_q) <= 32'(SLOTS))
		else $error("slot allocator past table size");
	a_ok_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_q.ok || out_q.error_code == ERR_NONE))
		else $error("successful result carries an error code");
	a_newslot_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.new_slot != 8'd0) |-> out_q.ok)
		else $error("new slot reported on failed command");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_valid_q && !m_tready) |=> (s1_valid_q && $stable(item_s1)))
		else $error("stage 1 command lost during stall");
	a_gen_step: assert property (@(posedge clk) disable iff (!arst_n)
		(gc_q != $past(gc_q)) |-> (gc_q == $past(gc_q) + 32'd1))
		else $error("generation counter jumped");
`endif
endmodule
